### design/periodic_timer_queue_unit_defines.svh
// Assertion helpers used by the timer queue datapath.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PERIODIC_TIMER_QUEUE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ptq_pkg.sv
package ptq_pkg;

  localparam int PTQ_DEPTH_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int PMS_W    = 16;
  localparam int TPM_W    = 20;
  localparam int TIME_W   = 48;
  localparam int PER_W    = 40;
  localparam int PROD_W   = PMS_W + TPM_W;
  localparam int STAT_W   = 2;
  localparam int QCNT_W   = 5;

  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1000);

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  // Memory read address selects.
  localparam int RD_SEL_W = 3;
  localparam logic [RD_SEL_W-1:0] RD_ZERO = 3'd0;
  localparam logic [RD_SEL_W-1:0] RD_P1   = 3'd1;
  localparam logic [RD_SEL_W-1:0] RD_P2   = 3'd2;
  localparam logic [RD_SEL_W-1:0] RD_M2   = 3'd3;
  localparam logic [RD_SEL_W-1:0] RD_CM1  = 3'd4;

  // Walk pointer operations.
  localparam int PTR_OP_W = 2;
  localparam logic [PTR_OP_W-1:0] PTR_HOLD = 2'd0;
  localparam logic [PTR_OP_W-1:0] PTR_INC  = 2'd1;
  localparam logic [PTR_OP_W-1:0] PTR_DEC  = 2'd2;
  localparam logic [PTR_OP_W-1:0] PTR_CNT  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    logic [PMS_W-1:0]    period_ms;
  } in_item_t;

  typedef struct packed {
    logic                fired;
    logic [HANDLE_W-1:0] fired_handle;
    logic [STAT_W-1:0]   status;
    logic [QCNT_W-1:0]   queue_count;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [PER_W-1:0]    period;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic                take;
    logic                rd_en;
    logic [RD_SEL_W-1:0] rd_sel;
    logic                wr_en;
    logic                wr_ent;
    logic [PTR_OP_W-1:0] ptr_op;
    logic                load_ent;
    logic                fire;
    logic                pend_set;
    logic                pend_clr;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                stat_we;
    logic [STAT_W-1:0]   stat_val;
    logic                finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_zero;
    logic              full;
    logic              due;
    logic              pend;
    logic              hmatch;
    logic              ptr_zero;
    logic              has_p1;
    logic              has_p2;
    logic              ptr_gt1;
    logic              dl_le;
    logic              out_free;
  } stat_t;

endpackage

### design/periodic_timer_queue_unit.sv
// Periodic timer queue: up to DEPTH periodic timers kept sorted by deadline.
// Input channel (in_valid/in_ready/in_data) takes one item at a time: a tick
// advances the 48-bit time counter and services at most the front timer, a
// set arms a timer period_ms * ticks_per_ms ticks from now, a clear removes
// the first timer with a matching handle (or marks the front for cancel).
// Every item gives exactly one result item on out_valid/out_ready/out_data.
// cfg_we/cfg_data write ticks_per_ms; write it only while the block is idle.
// After acceptance an item passes through dispatch, then any entry writes (none,
// one written in place, or a walk of the list for an insert or removal), then
// the result state that loads the output register.
// The walk moves one entry per cycle through the single write and single
// registered read port of the entry memory, so an item's run time grows with
// the number of entries it shifts or searches.
// in_ready is high only between items. A finished result sits in the output
// register, and the next item is accepted while it waits; if the receiver
// still stalls when that next result is ready, the block holds and keeps
// in_ready low until out_ready frees the output register.
// Reset (rst_n low, synchronous) empties the queue, zeroes time, clears any
// pending cancel and sets ticks_per_ms to 1000; it needs no clearing pass.
module periodic_timer_queue_unit #(
  parameter int DEPTH = ptq_pkg::PTQ_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ptq_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ptq_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [ptq_pkg::TPM_W-1:0] cfg_data
);
  import ptq_pkg::*;

  // The controller sequences each item; the datapath holds the entry memory,
  // time base, count and result registers and reports compare results.
  cmd_t  cmd;
  stat_t stat;

  ptq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### design/ptq_ctrl.sv
module ptq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptq_pkg::stat_t stat,
  output ptq_pkg::cmd_t  cmd
);
  import ptq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_SRCH     = 3'd2;
  localparam logic [2:0] ST_DN_DROP  = 3'd3;
  localparam logic [2:0] ST_DN_INS   = 3'd4;
  localparam logic [2:0] ST_UP       = 3'd5;
  localparam logic [2:0] ST_WR_E     = 3'd6;
  localparam logic [2:0] ST_RESULT   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       do_search;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    do_search = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_TICK: begin
            state_nxt = ST_RESULT;
            if (stat.due) begin
              if (stat.pend) begin
                cmd.pend_clr = 1'b1;
                cmd.cnt_dec  = 1'b1;
                if (stat.has_p1) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_P1;
                  state_nxt  = ST_DN_DROP;
                end
              end else begin
                cmd.fire     = 1'b1;
                cmd.load_ent = 1'b1;
                if (stat.has_p1) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_P1;
                  state_nxt  = ST_DN_INS;
                end else begin
                  state_nxt = ST_WR_E;
                end
              end
            end
          end
          MODE_SET: begin
            if (stat.full) begin
              cmd.stat_we  = 1'b1;
              cmd.stat_val = STAT_FULL;
              state_nxt    = ST_RESULT;
            end else begin
              cmd.load_ent = 1'b1;
              cmd.cnt_inc  = 1'b1;
              cmd.ptr_op   = PTR_CNT;
              if (stat.cnt_zero) begin
                state_nxt = ST_WR_E;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CM1;
                state_nxt  = ST_UP;
              end
            end
          end
          MODE_CLEAR: begin
            if (stat.cnt_zero) begin
              cmd.stat_we  = 1'b1;
              cmd.stat_val = STAT_NOTFOUND;
              state_nxt    = ST_RESULT;
            end else begin
              do_search = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_RESULT;
          end
        endcase
      end
      ST_SRCH: begin
        do_search = 1'b1;
      end
      ST_DN_DROP: begin
        cmd.wr_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        if (stat.has_p2) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_P2;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_DN_INS: begin
        cmd.wr_en = 1'b1;
        if (stat.dl_le) begin
          cmd.ptr_op = PTR_INC;
          if (stat.has_p2) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_P2;
          end else begin
            state_nxt = ST_WR_E;
          end
        end else begin
          cmd.wr_ent = 1'b1;
          state_nxt  = ST_RESULT;
        end
      end
      ST_UP: begin
        cmd.wr_en = 1'b1;
        if (!stat.dl_le) begin
          cmd.ptr_op = PTR_DEC;
          if (stat.ptr_gt1) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_M2;
          end else begin
            state_nxt = ST_WR_E;
          end
        end else begin
          cmd.wr_ent = 1'b1;
          state_nxt  = ST_RESULT;
        end
      end
      ST_WR_E: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_ent = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Handle compare step of a clear, shared by the first and later entries.
    if (do_search) begin
      if (stat.hmatch) begin
        if (stat.ptr_zero) begin
          cmd.pend_set = 1'b1;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.cnt_dec = 1'b1;
          if (stat.has_p1) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_P1;
            state_nxt  = ST_DN_DROP;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end else if (stat.has_p1) begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_P1;
        cmd.ptr_op = PTR_INC;
        state_nxt  = ST_SRCH;
      end else begin
        cmd.stat_we  = 1'b1;
        cmd.stat_val = STAT_NOTFOUND;
        state_nxt    = ST_RESULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ptq_datapath.sv
`include "periodic_timer_queue_unit_defines.svh"

module ptq_datapath #(
  parameter int DEPTH = ptq_pkg::PTQ_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ptq_pkg::in_item_t        in_data,
  input  logic                     cfg_we,
  input  logic [ptq_pkg::TPM_W-1:0] cfg_data,
  input  ptq_pkg::cmd_t            cmd,
  output ptq_pkg::stat_t           stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output ptq_pkg::out_item_t       out_data
);
  import ptq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int AX = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t              mem [DEPTH];
  entry_t              rdata_r;
  entry_t              ent_r;
  logic [MODE_W-1:0]   mode_r;
  logic [HANDLE_W-1:0] hd_r;
  logic [PER_W-1:0]    per_r;
  logic [TIME_W-1:0]   time_r;
  logic [TPM_W-1:0]    tpm_r;
  logic [CW-1:0]       cnt_r;
  logic [AW-1:0]       ptr_r;
  logic                pend_r;
  logic                inc_r;
  logic                dec_r;
  logic                fired_r;
  logic [HANDLE_W-1:0] fh_r;
  logic [STAT_W-1:0]   status_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [PROD_W-1:0]   prod;
  logic [AX-1:0]       ptr_x;
  logic [AX-1:0]       cnt_x;
  logic [AX-1:0]       rd_addr_x;
  logic [AW-1:0]       rd_addr;
  logic [TIME_W-1:0]   tick_dl;
  logic [TIME_W-1:0]   set_dl;
  logic [TIME_W-1:0]   base_dl;
  logic [TIME_W-1:0]   tie_dl;
  logic [CW-1:0]       cnt_adj;

  assign prod  = PROD_W'(in_data.period_ms) * PROD_W'(tpm_r);
  assign ptr_x = AX'(ptr_r);
  assign cnt_x = AX'(cnt_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr_x = '0;
      RD_P1:   rd_addr_x = ptr_x + AX'(1);
      RD_P2:   rd_addr_x = ptr_x + AX'(2);
      RD_M2:   rd_addr_x = ptr_x - AX'(2);
      RD_CM1:  rd_addr_x = cnt_x - AX'(1);
      default: rd_addr_x = '0;
    endcase
  end
  assign rd_addr = rd_addr_x[AW-1:0];

  // Re-armed timer goes one period past now; a new timer that would not
  // land after the front is pushed to one millisecond past the front.
  assign tick_dl = time_r + TIME_W'(rdata_r.period);
  assign base_dl = time_r + TIME_W'(per_r);
  assign tie_dl  = rdata_r.deadline + TIME_W'(tpm_r);
  assign set_dl  = (cnt_r != '0 && base_dl <= rdata_r.deadline) ? tie_dl : base_dl;

  assign cnt_adj = cnt_r + CW'(inc_r) - CW'(dec_r);

  assign stat.mode     = mode_r;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.full     = (cnt_r == CW'(DEPTH));
  assign stat.due      = (cnt_r != '0) && (time_r >= rdata_r.deadline);
  assign stat.pend     = pend_r;
  assign stat.hmatch   = (rdata_r.handle == hd_r);
  assign stat.ptr_zero = (ptr_r == '0);
  assign stat.has_p1   = (ptr_x + AX'(1)) < cnt_x;
  assign stat.has_p2   = (ptr_x + AX'(2)) < cnt_x;
  assign stat.ptr_gt1  = ptr_r > AW'(1);
  assign stat.dl_le    = (rdata_r.deadline <= ent_r.deadline);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[ptr_r] <= cmd.wr_ent ? ent_r : rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Item fields, the entry being placed and the result fields.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_r <= in_data.mode;
      hd_r   <= in_data.handle;
      per_r  <= PER_W'(prod);
    end
    if (cmd.load_ent) begin
      if (mode_r == MODE_TICK) begin
        ent_r <= '{deadline: tick_dl, period: rdata_r.period, handle: rdata_r.handle};
      end else begin
        ent_r <= '{deadline: set_dl, period: per_r, handle: hd_r};
      end
    end
    if (cmd.take) begin
      fired_r  <= 1'b0;
      fh_r     <= '0;
      status_r <= STAT_OK;
    end else begin
      if (cmd.fire) begin
        fired_r <= 1'b1;
        fh_r    <= rdata_r.handle;
      end
      if (cmd.stat_we) begin
        status_r <= cmd.stat_val;
      end
    end
    if (cmd.finish) begin
      out_data_r <= '{fired: fired_r, fired_handle: fh_r, status: status_r,
                      queue_count: QCNT_W'(cnt_adj)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      tpm_r       <= TPM_RESET;
      cnt_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      inc_r       <= 1'b0;
      dec_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tpm_r <= cfg_data;
      end
      if (cmd.take && in_data.mode == MODE_TICK) begin
        time_r <= time_r + TIME_W'(1);
      end
      if (cmd.take) begin
        ptr_r <= '0;
      end else begin
        case (cmd.ptr_op)
          PTR_HOLD: ptr_r <= ptr_r;
          PTR_INC:  ptr_r <= ptr_r + AW'(1);
          PTR_DEC:  ptr_r <= ptr_r - AW'(1);
          PTR_CNT:  ptr_r <= AW'(cnt_r);
          default:  ptr_r <= ptr_r;
        endcase
      end
      if (cmd.pend_set) begin
        pend_r <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_r <= 1'b0;
      end
      if (cmd.take) begin
        inc_r <= 1'b0;
        dec_r <= 1'b0;
      end else begin
        if (cmd.cnt_inc) begin
          inc_r <= 1'b1;
        end
        if (cmd.cnt_dec) begin
          dec_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        cnt_r       <= cnt_adj;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `PTQ_ASSERT_NOW(a_rd_wr_apart, cmd.rd_en && cmd.wr_en, rd_addr != ptr_r, "read and write collide")
  `PTQ_ASSERT_NOW(a_pend_nonempty, pend_r, cnt_r != '0, "cancel pending on empty queue")
  `PTQ_ASSERT_NEXT(a_cnt_only_at_finish, !cmd.finish, $stable(cnt_r), "count moved mid item")
  `PTQ_ASSERT_NOW(a_finish_free, cmd.finish, stat.out_free, "result overwrites waiting item")

endmodule

### test/periodic_timer_queue_unit_tb.sv
module periodic_timer_queue_unit_tb;
  import ptq_pkg::*;

  localparam int DEPTH = PTQ_DEPTH_DEF;
  // Idle time after each drain, to let the block settle before the time base
  // is changed.
  localparam int SETTLE_CYCLES = DEPTH + 8;
  // Cycles in a row without any handshake before the run is declared hung.
  // The longest legal quiet stretch is a long sender gap plus a long receiver
  // stall plus a full list walk, or a phase pause, all far below this.
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE = 10;
  localparam int PHASES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [TPM_W-1:0] cfg_data = '0;

  periodic_timer_queue_unit #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Items waiting to be sent, and the results the timer list predicts for the
  // items that the block has already taken.
  in_item_t pending_items[$];
  out_item_t expected_results[$];

  int mismatches = 0;
  int send_wait = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  // While set, neither side inserts gaps, so items run back to back.
  bit steady_flow = 1'b0;
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

  // Shadow copy of the timer list. Only entries below armed are ever read.
  logic [TIME_W-1:0] timer_dl [DEPTH];
  logic [PER_W-1:0] timer_per [DEPTH];
  logic [HANDLE_W-1:0] timer_hd [DEPTH];
  int unsigned armed;
  logic [TIME_W-1:0] tick_now;
  bit front_cancel;
  logic [TPM_W-1:0] tick_scale;

  // Removes the entry at pos and closes the gap behind it.
  function automatic void unlink_timer(int unsigned pos);
    for (int unsigned i = pos; i + 1 < armed; i++) begin
      timer_dl[i] = timer_dl[i + 1];
      timer_per[i] = timer_per[i + 1];
      timer_hd[i] = timer_hd[i + 1];
    end
    armed--;
  endfunction

  // Inserts behind every entry whose deadline is not later, so that timers
  // with equal deadlines keep their arrival order.
  function automatic void link_timer(logic [TIME_W-1:0] dl, logic [PER_W-1:0] per,
                                     logic [HANDLE_W-1:0] hd);
    int unsigned slot;
    slot = 0;
    while (slot < armed && timer_dl[slot] <= dl) slot++;
    for (int unsigned i = armed; i > slot; i--) begin
      timer_dl[i] = timer_dl[i - 1];
      timer_per[i] = timer_per[i - 1];
      timer_hd[i] = timer_hd[i - 1];
    end
    timer_dl[slot] = dl;
    timer_per[slot] = per;
    timer_hd[slot] = hd;
    armed++;
  endfunction

  // Applies one item to the shadow list and returns the result it must give.
  function automatic out_item_t next_result(in_item_t it);
    out_item_t res;
    logic [PER_W-1:0] per;
    logic [TIME_W-1:0] dl;
    logic [HANDLE_W-1:0] hd;
    int unsigned pos;
    res.fired = 1'b0;
    res.fired_handle = '0;
    res.status = STAT_OK;
    case (it.mode)
      MODE_TICK: begin
        tick_now = tick_now + TIME_W'(1);
        // Only the front timer is looked at, and only when it is due.
        if (armed > 0 && tick_now >= timer_dl[0]) begin
          per = timer_per[0];
          hd = timer_hd[0];
          unlink_timer(0);
          if (front_cancel) begin
            front_cancel = 1'b0;
          end else begin
            res.fired = 1'b1;
            res.fired_handle = hd;
            link_timer(tick_now + TIME_W'(per), per, hd);
          end
        end
      end
      MODE_SET: begin
        if (armed >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          per = PER_W'(it.period_ms) * PER_W'(tick_scale);
          dl = tick_now + TIME_W'(per);
          // A new timer never overtakes the front one: it lands one
          // millisecond behind it instead.
          if (armed > 0 && dl <= timer_dl[0]) dl = timer_dl[0] + TIME_W'(tick_scale);
          link_timer(dl, per, it.handle);
        end
      end
      MODE_CLEAR: begin
        pos = 0;
        while (pos < armed && timer_hd[pos] != it.handle) pos++;
        if (pos >= armed) begin
          res.status = STAT_NOTFOUND;
        end else if (pos == 0) begin
          front_cancel = 1'b1;
        end else begin
          unlink_timer(pos);
        end
      end
      default: begin
      end
    endcase
    res.queue_count = QCNT_W'(armed);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Most handles come from a small pool so that clears find their timers.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 85) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    return HANDLE_W'($urandom);
  endfunction

  // Ticks dominate so that timers come due; sets mostly use short periods,
  // with the odd full-range period to fill the back of the list.
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.handle = HANDLE_W'($urandom);
    it.period_ms = PMS_W'($urandom);
    if (r < 55) begin
      it.mode = MODE_TICK;
    end else if (r < 75) begin
      it.mode = MODE_SET;
      it.handle = pick_handle();
      r = $urandom_range(0, 99);
      if (r < 70) it.period_ms = PMS_W'($urandom_range(0, 12));
      else if (r < 96) it.period_ms = PMS_W'($urandom_range(0, 300));
    end else if (r < 95) begin
      it.mode = MODE_CLEAR;
      it.handle = pick_handle();
    end else begin
      // The fourth mode code is not an operation; the block just reports.
      it.mode = MODE_NOP;
    end
    return it;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result item with none expected: fired %0d handle %0d status %0d count %0d",
             got.fired, got.fired_handle, got.status, got.queue_count);
      mismatches++;
    end else begin
      want = expected_results[0];
      expected_results.delete(0);
      check_field("fired", 32'(want.fired), 32'(got.fired));
      check_field("fired_handle", 32'(want.fired_handle), 32'(got.fired_handle));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
    end
  endfunction

  // Sender. An item taken by the block is run through the shadow list right
  // away, so the expected results stay in acceptance order. A new item is
  // only presented once the previous one is gone and its gap has passed.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(next_result(in_data));
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items[0];
          pending_items.delete(0);
          in_valid <= 1'b1;
          send_wait <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. After each result item it may hold ready low for a while;
  // stall_left is private to this block, so blocking updates are safe here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        stall_left = pick_gap();
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Hang detection: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_item(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] hd,
                            logic [PMS_W-1:0] pms);
    in_item_t it;
    it.mode = mode;
    it.handle = hd;
    it.period_ms = pms;
    pending_items.push_back(it);
  endtask

  // Blocks until every queued item has been taken and answered. Sampling at
  // the falling edge sees the settled state of the rising-edge processes.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Changes the time base. Only called with the block idle, and the shadow
  // copy follows at once since no item is in flight.
  task automatic write_scale(logic [TPM_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    tick_scale = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [TPM_W-1:0] phase_scale [PHASES] = '{
    20'd1, 20'd2, 20'd0, 20'd1, 20'd5, 20'd1000, 20'd1000000, 20'hFFFFF
  };

  initial begin
    armed = 0;
    tick_now = '0;
    front_cancel = 1'b0;
    tick_scale = TPM_RESET;
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with one tick per millisecond, so deadlines are near.
    write_scale(20'd1);
    queue_item(MODE_TICK, 16'hFFFF, 16'hFFFF);  // tick on an empty list
    queue_item(MODE_SET, 16'h0000, 16'h0000);   // zero period, due next tick
    queue_item(MODE_TICK, 16'h0000, 16'h0000);  // fires and re-arms at now
    queue_item(MODE_SET, 16'hFFFF, 16'hFFFF);   // longest period goes to the back
    queue_item(MODE_SET, 16'h1234, 16'h0000);   // ties the front, pushed one ms later
    queue_item(MODE_CLEAR, 16'h0000, 16'h0000); // match at the front: cancel pending
    queue_item(MODE_TICK, 16'h0000, 16'h0000);  // cancelled front dropped silently
    queue_item(MODE_TICK, 16'h0000, 16'h0000);  // next timer fires
    queue_item(MODE_CLEAR, 16'hFFFF, 16'h0000); // match behind the front is removed
    queue_item(MODE_CLEAR, 16'hABCD, 16'h0000); // no such handle
    queue_item(MODE_NOP, 16'h5A5A, 16'hA5A5);   // unused mode code
    // Fill the list with short timers from the pool; the last set is
    // refused because the list is full.
    for (int i = 0; i < DEPTH; i++) begin
      queue_item(MODE_SET, handle_pool[i % POOL_SIZE], PMS_W'(i + 1));
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Random phases across the range of time bases, including zero and the
    // largest value the register holds. The large ones come last because
    // their timers end up at the front and never come due.
    for (int p = 0; p < PHASES; p++) begin
      write_scale(phase_scale[p]);
      steady_flow = (p == 1);
      for (int n = 0; n < 62; n++) pending_items.push_back(random_item());
      // The test waits here until every result of the phase is in.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
